// File: rtl/core/matrix3x3_inverse_unit_assert.svh
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define MX3I_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mx3i assertion failed");

// Implication in the next cycle.
`define MX3I_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mx3i assertion failed");

`endif

// File: rtl/core/mx3i_pkg.sv
// Types and constants for the 3x3 matrix inverse unit.
package mx3i_pkg;

	localparam int ELEM_W   = 32;
	localparam int COF_W    = 65;   // exact 2x2 minor
	localparam int TERM_W   = 97;   // element times cofactor
	localparam int DET_W    = 99;   // exact determinant
	localparam int DMAG_W   = 98;   // determinant magnitude
	localparam int QW       = 32;   // quotient bits before rounding
	localparam int NLANE    = 9;
	localparam int FRONT_LAT = 6;
	localparam int LANE_LAT  = QW + 3;
	localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic                     singular;
		logic                     overflow;
	} out_t;

	// Operands handed to one divider lane.
	typedef struct packed {
		logic [COF_W-1:0]  cmag;
		logic [DMAG_W-1:0] dmag;
		logic              neg;
		logic              sing;
	} lane_in_t;

	// What one lane returns.
	typedef struct packed {
		logic signed [ELEM_W-1:0] elem;
		logic                     ovf;
		logic                     sing;
	} lane_out_t;

	// Element indices (row-major) of each cofactor: p*q - r*s.
	typedef logic [3:0] idx_t;
	localparam idx_t COF_IDX [NLANE][4] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5},
		'{4'd6, 4'd5, 4'd3, 4'd8},
		'{4'd3, 4'd7, 4'd6, 4'd4},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd6, 4'd1, 4'd0, 4'd7},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd0, 4'd4, 4'd3, 4'd1}
	};

	// Output element (row, col) uses cofactor (col, row).
	localparam idx_t LANE_COF [NLANE] = '{
		4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
	};

endpackage

// File: rtl/core/matrix3x3_inverse_unit.sv
// Top level of the pipelined 3x3 matrix inverse unit.
// Usage:
//   in_valid/in_ready/in_data carry one 3x3 matrix of signed Q16.16
//   elements per transaction; out_valid/out_ready/out_data carry the
//   inverse, a singular flag and an overflow flag.
//   Throughput: one matrix per cycle unless the skid buffer is full.
//   Six front stages form the cofactors and determinant; nine divider
//   lanes, each a 35-stage pipeline with one quotient bit per stage,
//   form the elements side by side; the output register merges the
//   lane flags.
//   A singular matrix gives all-zero elements, singular=1, overflow=0.
//   An out-of-range element saturates and sets overflow.
//   Stall: the output register plus a one-entry skid buffer hold results;
//   the pipeline freezes only when the skid is full, so in_ready stays
//   high while a single result waits and drops from the cycle after a
//   second result lands in the skid buffer.
//   Reset (arst_n low) empties the pipeline and the output buffer.
`include "matrix3x3_inverse_unit_assert.svh"

module matrix3x3_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mx3i_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mx3i_pkg::out_t out_data
);

	localparam int NL = mx3i_pkg::NLANE;
	localparam int PL = mx3i_pkg::PIPE_LAT;

	logic                                 en;
	logic [PL-1:0]                        vld_q;
	mx3i_pkg::lane_in_t  [NL-1:0]         lane_in;
	mx3i_pkg::lane_out_t [NL-1:0]         lane_out;
	mx3i_pkg::out_t                       merged;
	mx3i_pkg::out_t                       sk_data_q;
	logic                                 sk_valid_q;
	logic                                 out_valid_q;
	mx3i_pkg::out_t                       out_data_q;
	logic                                 ovf_any;

	assign en       = !sk_valid_q;
	assign in_ready = en;

	// Valid tracking through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PL-2:0], in_valid};
		end
	end

	mx3i_front u_front (
		.clk     (clk),
		.en      (en),
		.in_data (in_data),
		.lane_in (lane_in)
	);

	for (genvar k = 0; k < NL; k++) begin : g_lane
		mx3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk      (clk),
			.en       (en),
			.lane_in  (lane_in[k]),
			.lane_out (lane_out[k])
		);
	end

	// Merge lane results
	always_comb begin
		ovf_any = 1'b0;
		for (int k = 0; k < NL; k++) ovf_any = ovf_any | lane_out[k].ovf;
		merged.r00      = lane_out[0].elem;
		merged.r01      = lane_out[1].elem;
		merged.r02      = lane_out[2].elem;
		merged.r10      = lane_out[3].elem;
		merged.r11      = lane_out[4].elem;
		merged.r12      = lane_out[5].elem;
		merged.r20      = lane_out[6].elem;
		merged.r21      = lane_out[7].elem;
		merged.r22      = lane_out[8].elem;
		merged.singular = lane_out[0].sing;
		merged.overflow = ovf_any;
	end

	// Output register and skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				if (sk_valid_q) begin
					sk_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (en && vld_q[PL-1]) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					sk_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready && sk_valid_q) begin
			out_data_q <= sk_data_q;
		end
		if (en && vld_q[PL-1]) begin
			if (!out_valid_q || out_ready) begin
				out_data_q <= merged;
			end else begin
				sk_data_q <= merged;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	`MX3I_ASSERT_IMPL(a_skid_needs_out, clk, arst_n, sk_valid_q, out_valid_q)
	`MX3I_ASSERT_IMPL(a_skid_fill, clk, arst_n, $rose(sk_valid_q), $past(out_valid_q && !out_ready))
	`MX3I_ASSERT_IMPL(a_singular_zero, clk, arst_n, out_valid_q && out_data_q.singular, !out_data_q.overflow && out_data_q.r00 == '0 && out_data_q.r22 == '0)

endmodule

// File: rtl/core/mx3i_front.sv
// Cofactors, determinant and sign/magnitude split for the inverse unit.
module mx3i_front (
	input  logic                                clk,
	input  logic                                en,
	input  mx3i_pkg::in_t                       in_data,
	output mx3i_pkg::lane_in_t [mx3i_pkg::NLANE-1:0] lane_in
);

	localparam int NL = mx3i_pkg::NLANE;
	localparam int EW = mx3i_pkg::ELEM_W;
	localparam int CW = mx3i_pkg::COF_W;
	localparam int TW = mx3i_pkg::TERM_W;
	localparam int DW = mx3i_pkg::DET_W;
	localparam int MW = mx3i_pkg::DMAG_W;

	logic signed [EW-1:0] e [NL];

	logic signed [2*EW-1:0] pa_s1 [NL];
	logic signed [2*EW-1:0] pb_s1 [NL];
	logic signed [EW-1:0]   row_s1 [3];

	logic signed [CW-1:0]   cof_s2 [NL];
	logic signed [EW-1:0]   row_s2 [3];

	logic signed [CW-1:0]   cof_s3 [NL];
	logic signed [CW-1:0]   mlo_s3 [3];
	logic signed [CW-1:0]   mhi_s3 [3];

	logic signed [CW-1:0]   cof_s4 [NL];
	logic signed [TW-1:0]   term_s4 [3];

	logic signed [CW-1:0]   cof_s5 [NL];
	logic signed [DW-1:0]   det_s5;

	logic [CW-1:0]          cmag_s6 [NL];
	logic                   cneg_s6 [NL];
	logic [MW-1:0]          dmag_s6;
	logic                   dneg_s6;
	logic                   sing_s6;

	assign e[0] = in_data.a00;
	assign e[1] = in_data.a01;
	assign e[2] = in_data.a02;
	assign e[3] = in_data.a10;
	assign e[4] = in_data.a11;
	assign e[5] = in_data.a12;
	assign e[6] = in_data.a20;
	assign e[7] = in_data.a21;
	assign e[8] = in_data.a22;

	// Stage 1: the eighteen 32x32 products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				pa_s1[k] <= e[mx3i_pkg::COF_IDX[k][0]] * e[mx3i_pkg::COF_IDX[k][1]];
				pb_s1[k] <= e[mx3i_pkg::COF_IDX[k][2]] * e[mx3i_pkg::COF_IDX[k][3]];
			end
			for (int j = 0; j < 3; j++) row_s1[j] <= e[j];
		end
	end

	// Stage 2: cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++)
				cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
			row_s2 <= row_s1;
		end
	end

	// Stage 3: first-row element times cofactor, split into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				mlo_s3[j] <= row_s2[j] * $signed({1'b0, cof_s2[j][EW-1:0]});
				mhi_s3[j] <= row_s2[j] * $signed(cof_s2[j][CW-1:EW]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// Stage 4: recombine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				term_s4[j] <= (TW'(mhi_s3[j]) <<< EW) + TW'(mlo_s3[j]);
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: determinant
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= DW'(term_s4[0]) + DW'(term_s4[1]) + DW'(term_s4[2]);
			cof_s5 <= cof_s4;
		end
	end

	// Stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				cneg_s6[k] <= cof_s5[k][CW-1];
				cmag_s6[k] <= cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k]);
			end
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= det_s5[DW-1] ? MW'(-det_s5) : MW'(det_s5);
			sing_s6 <= (det_s5 == '0);
		end
	end

	// Route the transposed cofactor to each lane
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			lane_in[k].cmag = cmag_s6[mx3i_pkg::LANE_COF[k]];
			lane_in[k].neg  = cneg_s6[mx3i_pkg::LANE_COF[k]] ^ dneg_s6;
			lane_in[k].dmag = dmag_s6;
			lane_in[k].sing = sing_s6;
		end
	end

endmodule

// File: rtl/core/mx3i_div_lane.sv
// One pipelined divider lane: rounded, saturated adj * 2^(2F) / det.
module mx3i_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  mx3i_pkg::lane_in_t   lane_in,
	output mx3i_pkg::lane_out_t  lane_out
);

	localparam int QW = mx3i_pkg::QW;
	localparam int MW = mx3i_pkg::DMAG_W;
	localparam int EW = mx3i_pkg::ELEM_W;
	localparam int NW = mx3i_pkg::COF_W + 2 * FRAC_BITS;
	localparam int DSW = MW + QW;
	localparam int W = ((NW > DSW) ? NW : DSW) + 1;

	logic [W-1:0]  rem_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic [MW-1:0] d_s    [QW+1];
	logic          neg_s  [QW+1];
	logic          ovf_s  [QW+1];
	logic          sing_s [QW+1];

	logic [QW:0]   qr_s33;
	logic          neg_s33;
	logic          ovf_s33;
	logic          sing_s33;

	logic [W-1:0]  num;
	logic [QW:0]   lim;
	logic          sat;

	// Precheck: a quotient of 2^32 or more always saturates
	assign num = W'(lane_in.cmag) << (2 * FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			q_s[0]    <= '0;
			d_s[0]    <= lane_in.dmag;
			neg_s[0]  <= lane_in.neg;
			sing_s[0] <= lane_in.sing;
			ovf_s[0]  <= (num >= (W'(lane_in.dmag) << QW));
		end
	end

	// Restoring division, one quotient bit per stage
	for (genvar i = 1; i <= QW; i++) begin : g_step
		localparam int B = QW - i;
		logic [W:0] diff;
		assign diff = {1'b0, rem_s[i-1]} - {1'b0, (W'(d_s[i-1]) << B)};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= diff[W] ? rem_s[i-1] : diff[W-1:0];
				q_s[i]    <= q_s[i-1] | (diff[W] ? QW'(0) : (QW'(1) << B));
				d_s[i]    <= d_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				ovf_s[i]  <= ovf_s[i-1];
				sing_s[i] <= sing_s[i-1];
			end
		end
	end

	// Round half away from zero on the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			qr_s33   <= {1'b0, q_s[QW]} +
				(QW+1)'({rem_s[QW][W-2:0], 1'b0} >= W'(d_s[QW]));
			neg_s33  <= neg_s[QW];
			ovf_s33  <= ovf_s[QW];
			sing_s33 <= sing_s[QW];
		end
	end

	// Saturate and apply sign
	assign lim = neg_s33 ? ((QW+1)'(1) << (EW-1)) : (((QW+1)'(1) << (EW-1)) - 1'b1);
	assign sat = ovf_s33 || (qr_s33 > lim);

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out.sing <= sing_s33;
			lane_out.ovf  <= !sing_s33 && sat;
			if (sing_s33)
				lane_out.elem <= '0;
			else if (sat)
				lane_out.elem <= neg_s33 ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
			else
				lane_out.elem <= neg_s33 ? EW'(-qr_s33[EW-1:0]) : qr_s33[EW-1:0];
		end
	end

endmodule
